### src/ps2c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2c_pkg
// shared codes and constants of the ps/2 controller with port queues
// ----------------------------------------------------------------------------
package ps2c_pkg;

  // default depth of each port receive queue
  localparam int unsigned QueueDepthDefault = 32;

  // item kinds
  localparam logic [1:0] CMD_BUS_READ  = 2'd0;
  localparam logic [1:0] CMD_BUS_WRITE = 2'd1;
  localparam logic [1:0] CMD_PUSH      = 2'd2;
  localparam logic [1:0] CMD_POLL      = 2'd3;

  // bus ports
  localparam logic BUS_DATA   = 1'b0;
  localparam logic BUS_CMDSTS = 1'b1;

  // device ports
  localparam logic PORT_KBD = 1'b0;
  localparam logic PORT_AUX = 1'b1;

  // controller command codes
  localparam logic [7:0] CTL_READ_CFG   = 8'h20;
  localparam logic [7:0] CTL_WRITE_CFG  = 8'h60;
  localparam logic [7:0] CTL_AUX_OFF    = 8'hA7;
  localparam logic [7:0] CTL_AUX_ON     = 8'hA8;
  localparam logic [7:0] CTL_AUX_TEST   = 8'hA9;
  localparam logic [7:0] CTL_SELF_TEST  = 8'hAA;
  localparam logic [7:0] CTL_KBD_TEST   = 8'hAB;
  localparam logic [7:0] CTL_KBD_OFF    = 8'hAD;
  localparam logic [7:0] CTL_KBD_ON     = 8'hAE;
  localparam logic [7:0] CTL_WRITE_OUT  = 8'hD1;
  localparam logic [7:0] CTL_KBD_INJECT = 8'hD2;
  localparam logic [7:0] CTL_AUX_INJECT = 8'hD3;
  localparam logic [7:0] CTL_AUX_WRITE  = 8'hD4;

  // answers
  localparam logic [7:0] ANS_TEST_OK  = 8'h00;
  localparam logic [7:0] ANS_SELF_OK  = 8'h55;

  // reset value of the configuration byte
  localparam logic [7:0] SETUP_RESET = 8'h47;

  // status bit positions
  localparam int unsigned STS_OBF  = 0;
  localparam int unsigned STS_SYS  = 2;
  localparam int unsigned STS_CMD  = 3;

  // irq and forward codes
  localparam logic [1:0] IRQ_NONE = 2'd0;
  localparam logic [1:0] IRQ_KBD  = 2'd1;
  localparam logic [1:0] IRQ_AUX  = 2'd2;
  localparam logic [1:0] FWD_NONE = 2'd0;
  localparam logic [1:0] FWD_KBD  = 2'd1;
  localparam logic [1:0] FWD_AUX  = 2'd2;

endpackage
`default_nettype wire

### src/ps2_controller_with_port_queues_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_controller_with_port_queues_core
// 8042-style ps/2 controller with one receive queue per device port
// ----------------------------------------------------------------------------
// usage:
//   the input channel (in_valid_i/in_ready_o) carries one transaction per
//   item: a cpu bus read, a cpu bus write to the data or command port, a
//   device byte pushed into a port queue, or an interrupt poll for one port.
//   every item yields exactly one result transaction on the output channel
//   (out_valid_o/out_ready_i), in order.
//   the result appears in the output register in the cycle after the input
//   transaction; one item per cycle is taken while the output drains. the
//   queue bytes live in a single synchronous ram; a poll reads the head
//   entry at its accept edge and the byte lands in the output buffer in the
//   following cycle, with a bypass so the very next item already sees it.
//   stall: while a result waits in the output register and out_ready_i is
//   low, in_ready_o is low; the block holds all state until it drains.
//   reset: status, output buffer and pending command clear, the
//   configuration byte becomes 0x47, both ports are enabled and both queues
//   are empty. the queue ram itself is not cleared, so no reset pass is
//   needed and the block takes items right after reset.
// ----------------------------------------------------------------------------
module ps2_controller_with_port_queues_core #(
  parameter int unsigned QUEUE_DEPTH = ps2c_pkg::QueueDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic       bus_port_i,
  input  wire logic       device_port_i,
  input  wire logic [7:0] data_i,
  // output channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o,
  output logic            accepted_o,
  output logic [1:0]      irq_line_o,
  output logic [1:0]      forward_kind_o,
  output logic [7:0]      forward_byte_o,
  output logic            stop_request_o,
  output logic            a20_write_o,
  output logic            a20_value_o
);

  localparam int unsigned PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned MemD  = 2 * QUEUE_DEPTH;
  localparam int unsigned AddrW = $clog2(MemD);

  // wrapping pointer increment
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  // controller registers
  logic [7:0] status_q, status_d;
  logic [7:0] obuf_q, obuf_d;
  logic [7:0] setup_q, setup_d;
  logic [7:0] pend_q, pend_d;
  logic [1:0] en_q, en_d;

  // queue bookkeeping per port
  logic [PtrW-1:0] head_q [2];
  logic [PtrW-1:0] tail_q [2];
  logic [1:0]      empty_q;

  // queue ram and its registered read port
  logic [7:0] queue_mem_q [MemD];
  logic [7:0] rdata_q;
  logic       rd_pend_q;   // rdata_q still has to be committed to obuf_q

  // output register
  logic       out_valid_q;
  logic [7:0] read_data_q, read_data_d;
  logic       accepted_q, accepted_d;
  logic [1:0] irq_q, irq_d;
  logic [1:0] fkind_q, fkind_d;
  logic [7:0] fbyte_q, fbyte_d;
  logic       stop_q, stop_d;
  logic       a20w_q, a20w_d;
  logic       a20v_q, a20v_d;

  logic in_fire;
  logic out_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // output buffer as seen by the current item, with bypass of a fresh pop
  logic [7:0] obuf_cur;
  assign obuf_cur = rd_pend_q ? rdata_q : obuf_q;

  // data write that a pending command consumes
  logic pend_write;
  assign pend_write = (command_i == ps2c_pkg::CMD_BUS_WRITE) &&
                      (bus_port_i == ps2c_pkg::BUS_DATA) && status_q[ps2c_pkg::STS_CMD];

  // push: direct device push or injection via pending command
  logic push_req;
  logic push_port;
  logic push_ok;
  logic push_fire;
  assign push_req  = (command_i == ps2c_pkg::CMD_PUSH) ||
                     (pend_write && ((pend_q == ps2c_pkg::CTL_KBD_INJECT) ||
                                     (pend_q == ps2c_pkg::CTL_AUX_INJECT)));
  assign push_port = (command_i == ps2c_pkg::CMD_PUSH) ? device_port_i :
                     (pend_q == ps2c_pkg::CTL_AUX_INJECT);
  assign push_ok   = en_q[push_port] &&
                     !(!empty_q[push_port] && (head_q[push_port] == tail_q[push_port]));
  assign push_fire = in_fire && push_req && push_ok;

  // poll: move the queue head into the output buffer
  logic pop_ok;
  logic pop_fire;
  assign pop_ok   = setup_q[device_port_i] && en_q[device_port_i] &&
                    !empty_q[device_port_i];
  assign pop_fire = in_fire && (command_i == ps2c_pkg::CMD_POLL) && pop_ok;

  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  assign wr_addr = push_port ? AddrW'(QUEUE_DEPTH) + AddrW'(tail_q[1]) : AddrW'(tail_q[0]);
  assign rd_addr = device_port_i ? AddrW'(QUEUE_DEPTH) + AddrW'(head_q[1])
                                 : AddrW'(head_q[0]);

  // main decode of one item
  always_comb begin
    status_d    = status_q;
    obuf_d      = obuf_cur;
    setup_d     = setup_q;
    pend_d      = pend_q;
    en_d        = en_q;
    read_data_d = '0;
    accepted_d  = 1'b0;
    irq_d       = ps2c_pkg::IRQ_NONE;
    fkind_d     = ps2c_pkg::FWD_NONE;
    fbyte_d     = '0;
    stop_d      = 1'b0;
    a20w_d      = 1'b0;
    a20v_d      = 1'b0;
    unique case (command_i)
      ps2c_pkg::CMD_BUS_READ: begin
        if (bus_port_i == ps2c_pkg::BUS_CMDSTS) begin
          status_d[ps2c_pkg::STS_SYS] = 1'b1;
          read_data_d = status_d;
        end else begin
          status_d[ps2c_pkg::STS_OBF] = 1'b0;
          read_data_d = obuf_cur;
        end
      end
      ps2c_pkg::CMD_BUS_WRITE: begin
        if (bus_port_i == ps2c_pkg::BUS_CMDSTS) begin
          unique case (data_i)
            ps2c_pkg::CTL_READ_CFG: begin
              obuf_d = setup_q;
              status_d[ps2c_pkg::STS_OBF] = 1'b1;
            end
            ps2c_pkg::CTL_WRITE_CFG, ps2c_pkg::CTL_WRITE_OUT, ps2c_pkg::CTL_KBD_INJECT,
            ps2c_pkg::CTL_AUX_INJECT, ps2c_pkg::CTL_AUX_WRITE: begin
              pend_d = data_i;
              status_d[ps2c_pkg::STS_CMD] = 1'b1;
            end
            ps2c_pkg::CTL_AUX_OFF: en_d[ps2c_pkg::PORT_AUX] = 1'b0;
            ps2c_pkg::CTL_AUX_ON:  en_d[ps2c_pkg::PORT_AUX] = 1'b1;
            ps2c_pkg::CTL_KBD_OFF: en_d[ps2c_pkg::PORT_KBD] = 1'b0;
            ps2c_pkg::CTL_KBD_ON:  en_d[ps2c_pkg::PORT_KBD] = 1'b1;
            ps2c_pkg::CTL_AUX_TEST, ps2c_pkg::CTL_KBD_TEST: begin
              obuf_d = ps2c_pkg::ANS_TEST_OK;
              status_d[ps2c_pkg::STS_OBF] = 1'b1;
            end
            ps2c_pkg::CTL_SELF_TEST: begin
              obuf_d = ps2c_pkg::ANS_SELF_OK;
              status_d[ps2c_pkg::STS_OBF] = 1'b1;
            end
            default: begin
              // even codes from 0xf0 pulse the cpu reset line
              stop_d = (data_i[7:4] == 4'hF) && !data_i[0];
            end
          endcase
        end else if (status_q[ps2c_pkg::STS_CMD]) begin
          status_d[ps2c_pkg::STS_CMD] = 1'b0;
          unique case (pend_q)
            ps2c_pkg::CTL_WRITE_CFG: setup_d = data_i;
            ps2c_pkg::CTL_WRITE_OUT: begin
              stop_d = !data_i[0];
              a20w_d = 1'b1;
              a20v_d = data_i[1];
            end
            ps2c_pkg::CTL_KBD_INJECT, ps2c_pkg::CTL_AUX_INJECT: accepted_d = push_ok;
            ps2c_pkg::CTL_AUX_WRITE: begin
              if (en_q[ps2c_pkg::PORT_AUX]) begin
                fkind_d = ps2c_pkg::FWD_AUX;
                fbyte_d = data_i;
              end
            end
            default: ;
          endcase
        end else if (en_q[ps2c_pkg::PORT_KBD]) begin
          fkind_d = ps2c_pkg::FWD_KBD;
          fbyte_d = data_i;
        end
      end
      ps2c_pkg::CMD_PUSH: accepted_d = push_ok;
      ps2c_pkg::CMD_POLL: begin
        if (pop_ok) begin
          // the byte itself arrives from the ram next cycle
          status_d[ps2c_pkg::STS_OBF] = 1'b1;
          accepted_d = 1'b1;
          irq_d = device_port_i ? ps2c_pkg::IRQ_AUX : ps2c_pkg::IRQ_KBD;
        end
      end
      default: ;
    endcase
  end

  // controller registers; a fresh pop commits the ram byte, directly when no item is taken, else via the decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= '0;
      obuf_q    <= '0;
      setup_q   <= ps2c_pkg::SETUP_RESET;
      pend_q    <= '0;
      en_q      <= 2'b11;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= pop_fire;
      if (in_fire) begin
        status_q <= status_d;
        obuf_q   <= obuf_d;
        setup_q  <= setup_d;
        pend_q   <= pend_d;
        en_q     <= en_d;
      end else begin
        obuf_q   <= obuf_cur;
      end
    end
  end

  // queue pointers and empty flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q[0] <= '0;
      head_q[1] <= '0;
      tail_q[0] <= '0;
      tail_q[1] <= '0;
      empty_q   <= 2'b11;
    end else begin
      if (push_fire) begin
        tail_q[push_port]  <= ptr_inc(tail_q[push_port]);
        empty_q[push_port] <= 1'b0;
      end
      if (pop_fire) begin
        head_q[device_port_i] <= ptr_inc(head_q[device_port_i]);
        if (ptr_inc(head_q[device_port_i]) == tail_q[device_port_i]) begin
          empty_q[device_port_i] <= 1'b1;
        end
      end
    end
  end

  // queue ram: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      queue_mem_q[wr_addr] <= data_i;
    end
    if (pop_fire) begin
      rdata_q <= queue_mem_q[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      read_data_q <= read_data_d;
      accepted_q  <= accepted_d;
      irq_q       <= irq_d;
      fkind_q     <= fkind_d;
      fbyte_q     <= fbyte_d;
      stop_q      <= stop_d;
      a20w_q      <= a20w_d;
      a20v_q      <= a20v_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = read_data_q;
  assign accepted_o     = accepted_q;
  assign irq_line_o     = irq_q;
  assign forward_kind_o = fkind_q;
  assign forward_byte_o = fbyte_q;
  assign stop_request_o = stop_q;
  assign a20_write_o    = a20w_q;
  assign a20_value_o    = a20v_q;

  // an empty queue has its pointers together
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_q[0] || head_q[0] == tail_q[0]) && (!empty_q[1] || head_q[1] == tail_q[1]))
    else $error("empty queue with split pointers");

  // a pop raises the output-full flag and arms the ram commit
  a_pop_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_fire |=> rd_pend_q && status_q[ps2c_pkg::STS_OBF])
    else $error("pop did not commit to output buffer");

  // a stored push leaves its queue non-empty
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fire |=> !empty_q[$past(push_port)])
    else $error("push left queue empty");

  // an irq only comes with a delivered byte
  a_irq_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && irq_line_o != ps2c_pkg::IRQ_NONE) |-> accepted_o)
    else $error("irq without delivered byte");

  // no forwarded byte without a target
  a_fwd_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && forward_kind_o == ps2c_pkg::FWD_NONE) |-> forward_byte_o == 8'h00)
    else $error("forward byte without target");

endmodule
`default_nettype wire

### sim/tb_ps2_controller_with_port_queues_core.sv
// ----------------------------------------------------------------------------
// tb_ps2_controller_with_port_queues_core
// self-checking bench for the 8042-style controller with per-port queues
// ----------------------------------------------------------------------------
// a cycle-free predictor of the controller (status, output buffer,
// configuration byte, pending command, port enables, two ring queues) runs on
// every input transaction and queues the expected result. a checker compares
// each output transaction field by field against the oldest expectation.
// stimulus: a short directed pass over commands and corner cases, then random
// queue fill/drain bursts, well-formed command sequences and raw noise, with
// random idle bursts on both channels and a back-to-back tail.
// ----------------------------------------------------------------------------
module tb_ps2_controller_with_port_queues_core;

  localparam int unsigned QDEPTH         = ps2c_pkg::QueueDepthDefault;
  localparam int          WATCHDOG_LIMIT = 500;

  // codes the package does not name
  localparam logic [7:0] STOP_BASE  = 8'hF0;  // even codes from here up stop the machine
  localparam logic [7:0] CTL_UNIMPL = 8'hD0;  // output port read, left out, ignored

  // one result transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic       accepted;
    logic [1:0] irq_line;
    logic [1:0] forward_kind;
    logic [7:0] forward_byte;
    logic       stop_request;
    logic       a20_write;
    logic       a20_value;
  } ps2_result_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid      = 1'b0;
  logic [1:0] command       = ps2c_pkg::CMD_BUS_READ;
  logic       bus_port      = ps2c_pkg::BUS_DATA;
  logic       device_port   = ps2c_pkg::PORT_KBD;
  logic [7:0] data          = 8'h00;
  logic       out_ready     = 1'b1;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] read_data_o;
  logic       accepted_o;
  logic [1:0] irq_line_o;
  logic [1:0] forward_kind_o;
  logic [7:0] forward_byte_o;
  logic       stop_request_o;
  logic       a20_write_o;
  logic       a20_value_o;

  // predicted controller state
  bit [7:0]    sts_model;
  bit [7:0]    obuf_model;
  bit [7:0]    setup_model;
  bit [7:0]    pending_model;
  bit          port_on   [2];
  bit [7:0]    ring_mem  [2][QDEPTH];
  int unsigned ring_head [2];
  int unsigned ring_tail [2];
  bit          ring_empty[2];

  ps2_result_t expected_results[$];

  bit idle_on;
  int items_sent;
  int results_checked;
  int err_count;
  int stall_cycles;
  int polls_delivered;
  int pushes_refused;
  int bytes_forwarded;
  int stops_seen;

  ps2_controller_with_port_queues_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .command_i     (command),
    .bus_port_i    (bus_port),
    .device_port_i (device_port),
    .data_i        (data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .read_data_o   (read_data_o),
    .accepted_o    (accepted_o),
    .irq_line_o    (irq_line_o),
    .forward_kind_o(forward_kind_o),
    .forward_byte_o(forward_byte_o),
    .stop_request_o(stop_request_o),
    .a20_write_o   (a20_write_o),
    .a20_value_o   (a20_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  task automatic reset_controller_model();
    sts_model     = '0;
    obuf_model    = '0;
    setup_model   = ps2c_pkg::SETUP_RESET;
    pending_model = '0;
    for (int p = 0; p < 2; p++) begin
      port_on[p]    = 1'b1;
      ring_head[p]  = 0;
      ring_tail[p]  = 0;
      ring_empty[p] = 1'b1;
    end
  endtask

  // device byte into a port queue; refused when the port is off or the ring full
  function automatic bit enqueue_port_byte(input bit p, input bit [7:0] b);
    if (!port_on[p]) return 1'b0;
    if (!ring_empty[p] && ring_head[p] == ring_tail[p]) return 1'b0;
    ring_mem[p][ring_tail[p]] = b;
    ring_tail[p]  = (ring_tail[p] + 1) % QDEPTH;
    ring_empty[p] = 1'b0;
    return 1'b1;
  endfunction

  // controller answer lands in the output buffer and sets output-full
  function automatic void load_answer(input bit [7:0] b);
    obuf_model                   = b;
    sts_model[ps2c_pkg::STS_OBF] = 1'b1;
  endfunction

  task automatic predict_controller_result(input bit [1:0] cmd, input bit bp, input bit dp,
                                           input bit [7:0] d, output ps2_result_t r);
    r = '0;
    case (cmd)
      ps2c_pkg::CMD_BUS_READ: begin
        if (bp == ps2c_pkg::BUS_CMDSTS) begin
          sts_model[ps2c_pkg::STS_SYS] = 1'b1;
          r.read_data                  = sts_model;
        end else begin
          // data read returns the buffer even when nothing new is in it
          sts_model[ps2c_pkg::STS_OBF] = 1'b0;
          r.read_data                  = obuf_model;
        end
      end
      ps2c_pkg::CMD_BUS_WRITE: begin
        if (bp == ps2c_pkg::BUS_CMDSTS) begin
          case (d)
            ps2c_pkg::CTL_READ_CFG: load_answer(setup_model);
            ps2c_pkg::CTL_WRITE_CFG, ps2c_pkg::CTL_WRITE_OUT, ps2c_pkg::CTL_KBD_INJECT,
            ps2c_pkg::CTL_AUX_INJECT, ps2c_pkg::CTL_AUX_WRITE: begin
              pending_model                = d;
              sts_model[ps2c_pkg::STS_CMD] = 1'b1;
            end
            ps2c_pkg::CTL_AUX_OFF:   port_on[ps2c_pkg::PORT_AUX] = 1'b0;
            ps2c_pkg::CTL_AUX_ON:    port_on[ps2c_pkg::PORT_AUX] = 1'b1;
            ps2c_pkg::CTL_AUX_TEST:  load_answer(ps2c_pkg::ANS_TEST_OK);
            ps2c_pkg::CTL_SELF_TEST: load_answer(ps2c_pkg::ANS_SELF_OK);
            ps2c_pkg::CTL_KBD_TEST:  load_answer(ps2c_pkg::ANS_TEST_OK);
            ps2c_pkg::CTL_KBD_OFF:   port_on[ps2c_pkg::PORT_KBD] = 1'b0;
            ps2c_pkg::CTL_KBD_ON:    port_on[ps2c_pkg::PORT_KBD] = 1'b1;
            default: begin
              // even codes at the top request a cpu reset, the rest are ignored
              if (d >= STOP_BASE && !d[0]) r.stop_request = 1'b1;
            end
          endcase
        end else if (sts_model[ps2c_pkg::STS_CMD]) begin
          // pending command eats this data byte
          sts_model[ps2c_pkg::STS_CMD] = 1'b0;
          case (pending_model)
            ps2c_pkg::CTL_WRITE_CFG: setup_model = d;
            ps2c_pkg::CTL_WRITE_OUT: begin
              r.stop_request = !d[0];
              r.a20_write    = 1'b1;
              r.a20_value    = d[1];
            end
            ps2c_pkg::CTL_KBD_INJECT: r.accepted = enqueue_port_byte(ps2c_pkg::PORT_KBD, d);
            ps2c_pkg::CTL_AUX_INJECT: r.accepted = enqueue_port_byte(ps2c_pkg::PORT_AUX, d);
            ps2c_pkg::CTL_AUX_WRITE: begin
              if (port_on[ps2c_pkg::PORT_AUX]) begin
                r.forward_kind = ps2c_pkg::FWD_AUX;
                r.forward_byte = d;
              end
            end
            default: ;
          endcase
        end else if (port_on[ps2c_pkg::PORT_KBD]) begin
          // bare data write goes to the keyboard
          r.forward_kind = ps2c_pkg::FWD_KBD;
          r.forward_byte = d;
        end
      end
      ps2c_pkg::CMD_PUSH: begin
        r.accepted = enqueue_port_byte(dp, d);
        if (!r.accepted) pushes_refused++;
      end
      default: begin
        // poll: configuration bit 0 gates the keyboard irq, bit 1 the mouse irq
        if (setup_model[dp] && port_on[dp] && !ring_empty[dp]) begin
          obuf_model                   = ring_mem[dp][ring_head[dp]];
          sts_model[ps2c_pkg::STS_OBF] = 1'b1;
          ring_head[dp]                = (ring_head[dp] + 1) % QDEPTH;
          if (ring_head[dp] == ring_tail[dp]) ring_empty[dp] = 1'b1;
          r.accepted = 1'b1;
          r.irq_line = dp ? ps2c_pkg::IRQ_AUX : ps2c_pkg::IRQ_KBD;
          polls_delivered++;
        end
      end
    endcase
    if (r.forward_kind != ps2c_pkg::FWD_NONE) bytes_forwarded++;
    if (r.stop_request) stops_seen++;
  endtask

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // one input transaction; called at a rising edge, returns at the accept edge
  task automatic send_item(input bit [1:0] cmd, input bit bp, input bit dp, input bit [7:0] d);
    ps2_result_t r;
    bit          fire;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    bus_port    <= bp;
    device_port <= dp;
    data        <= d;
    fire = 1'b0;
    // ready is sampled mid-cycle where it has settled for the coming edge
    while (!fire) begin
      @(negedge clk_i);
      fire = in_ready_o;
      @(posedge clk_i);
    end
    predict_controller_result(cmd, bp, dp, d, r);
    expected_results.push_back(r);
    items_sent++;
  endtask

  task automatic bus_read(input bit port);
    send_item(ps2c_pkg::CMD_BUS_READ, port, 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic bus_write(input bit port, input bit [7:0] d);
    send_item(ps2c_pkg::CMD_BUS_WRITE, port, 1'($urandom_range(0, 1)), d);
  endtask

  task automatic device_push(input bit p, input bit [7:0] d);
    send_item(ps2c_pkg::CMD_PUSH, 1'($urandom_range(0, 1)), p, d);
  endtask

  task automatic device_poll(input bit p);
    send_item(ps2c_pkg::CMD_POLL, 1'($urandom_range(0, 1)), p, 8'($urandom_range(0, 255)));
  endtask

  // mostly keeps both irq enable bits set so polls deliver
  function automatic bit [7:0] irq_friendly_setup();
    bit [7:0] v;
    v = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) v[1:0] = 2'b11;
    return v;
  endfunction

  function automatic bit [7:0] pick_ctl_code();
    bit [2:0] k;
    k = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 18))
      0:       return ps2c_pkg::CTL_READ_CFG;
      1:       return ps2c_pkg::CTL_WRITE_CFG;
      2:       return ps2c_pkg::CTL_WRITE_OUT;
      3:       return ps2c_pkg::CTL_KBD_INJECT;
      4:       return ps2c_pkg::CTL_AUX_INJECT;
      5:       return ps2c_pkg::CTL_AUX_WRITE;
      6:       return ps2c_pkg::CTL_AUX_OFF;
      7, 8:    return ps2c_pkg::CTL_AUX_ON;
      9:       return ps2c_pkg::CTL_AUX_TEST;
      10:      return ps2c_pkg::CTL_SELF_TEST;
      11:      return ps2c_pkg::CTL_KBD_TEST;
      12:      return ps2c_pkg::CTL_KBD_OFF;
      13, 14:  return ps2c_pkg::CTL_KBD_ON;
      15:      return {STOP_BASE[7:4], k, 1'b0};
      16:      return CTL_UNIMPL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // output side
  // --------------------------------------------------------------------------

  // random stall bursts on the result channel, none while idling is off
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_count++;
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             results_checked, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // result transactions are compared where the handshake is stable, mid-cycle
  always @(negedge clk_i) begin
    ps2_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, read_data", read_data_o, 8'h00);
      end else begin
        want = expected_results.pop_front();
        check_field("read_data", read_data_o, want.read_data);
        check_field("accepted", 8'(accepted_o), 8'(want.accepted));
        check_field("irq_line", 8'(irq_line_o), 8'(want.irq_line));
        check_field("forward_kind", 8'(forward_kind_o), 8'(want.forward_kind));
        check_field("forward_byte", forward_byte_o, want.forward_byte);
        check_field("stop_request", 8'(stop_request_o), 8'(want.stop_request));
        check_field("a20_write", 8'(a20_write_o), 8'(want.a20_write));
        check_field("a20_value", 8'(a20_value_o), 8'(want.a20_value));
      end
      results_checked++;
    end
  end

  // ends the run when neither channel moves for too long
  always @(negedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset values through status and data reads, then the configuration byte
  task automatic test_power_on();
    bus_read(ps2c_pkg::BUS_CMDSTS);
    bus_read(ps2c_pkg::BUS_DATA);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_READ_CFG);
    bus_read(ps2c_pkg::BUS_DATA);
  endtask

  task automatic test_self_tests();
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_SELF_TEST);
    bus_read(ps2c_pkg::BUS_DATA);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_AUX_TEST);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_KBD_TEST);
    bus_read(ps2c_pkg::BUS_CMDSTS);
  endtask

  // poll blocked by a clear irq bit, then delivered once the bit is set
  task automatic test_setup_gates_poll();
    device_push(ps2c_pkg::PORT_KBD, 8'hFF);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_WRITE_CFG);
    bus_write(ps2c_pkg::BUS_DATA, 8'h00);
    device_poll(ps2c_pkg::PORT_KBD);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_WRITE_CFG);
    bus_write(ps2c_pkg::BUS_DATA, 8'hFF);
    device_poll(ps2c_pkg::PORT_KBD);
    bus_read(ps2c_pkg::BUS_DATA);
  endtask

  // bare data goes to the keyboard, 0xd4 data to the mouse, none when disabled
  task automatic test_forwarding();
    bus_write(ps2c_pkg::BUS_DATA, 8'h00);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_AUX_WRITE);
    bus_write(ps2c_pkg::BUS_DATA, 8'hFF);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_AUX_OFF);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_AUX_WRITE);
    bus_write(ps2c_pkg::BUS_DATA, 8'h5A);
    device_push(ps2c_pkg::PORT_AUX, 8'h33);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_AUX_ON);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_KBD_OFF);
    bus_write(ps2c_pkg::BUS_DATA, 8'hA5);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_KBD_ON);
  endtask

  // output port write, cpu stop codes, the ignored code and mouse injection
  task automatic test_output_port_and_stops();
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_WRITE_OUT);
    bus_write(ps2c_pkg::BUS_DATA, 8'h02);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_WRITE_OUT);
    bus_write(ps2c_pkg::BUS_DATA, 8'hFD);
    bus_write(ps2c_pkg::BUS_CMDSTS, 8'hFE);
    bus_write(ps2c_pkg::BUS_CMDSTS, STOP_BASE);
    bus_write(ps2c_pkg::BUS_CMDSTS, 8'hF1);
    bus_write(ps2c_pkg::BUS_CMDSTS, CTL_UNIMPL);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_AUX_INJECT);
    bus_write(ps2c_pkg::BUS_DATA, 8'h80);
    device_poll(ps2c_pkg::PORT_AUX);
  endtask

  // fill and drain bursts; bursts past the ring depth hit the full case
  task automatic test_queue_fill_drain(input int n);
    int start;
    bit p;
    start = items_sent;
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_AUX_ON);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_KBD_ON);
    bus_write(ps2c_pkg::BUS_CMDSTS, ps2c_pkg::CTL_WRITE_CFG);
    bus_write(ps2c_pkg::BUS_DATA, 8'h03 | irq_friendly_setup());
    while (items_sent - start < n) begin
      p = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 36)) begin
        if ($urandom_range(0, 9) == 0) device_push(!p, 8'($urandom_range(0, 255)));
        else device_push(p, 8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(1, 36)) begin
        device_poll(p);
        if ($urandom_range(0, 1) != 0) bus_read(ps2c_pkg::BUS_DATA);
        else if ($urandom_range(0, 7) == 0) bus_read(ps2c_pkg::BUS_CMDSTS);
      end
    end
  endtask

  // command codes mostly followed by their data byte, sometimes broken off
  task automatic test_command_sequences(input int n);
    int start;
    bit [7:0] code;
    start = items_sent;
    while (items_sent - start < n) begin
      case ($urandom_range(0, 9))
        0: bus_read(1'($urandom_range(0, 1)));
        1: bus_write(ps2c_pkg::BUS_DATA, 8'($urandom_range(0, 255)));
        2: device_push(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        3: device_poll(1'($urandom_range(0, 1)));
        default: begin
          code = pick_ctl_code();
          bus_write(ps2c_pkg::BUS_CMDSTS, code);
          if (code inside {ps2c_pkg::CTL_WRITE_CFG, ps2c_pkg::CTL_WRITE_OUT,
                           ps2c_pkg::CTL_KBD_INJECT, ps2c_pkg::CTL_AUX_INJECT,
                           ps2c_pkg::CTL_AUX_WRITE} && $urandom_range(0, 7) != 0) begin
            if (code == ps2c_pkg::CTL_WRITE_CFG) begin
              bus_write(ps2c_pkg::BUS_DATA, irq_friendly_setup());
            end else begin
              bus_write(ps2c_pkg::BUS_DATA, 8'($urandom_range(0, 255)));
            end
          end
          if ($urandom_range(0, 1) != 0) bus_read(ps2c_pkg::BUS_DATA);
        end
      endcase
    end
  endtask

  task automatic test_random_noise(input int n);
    repeat (n)
      send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    reset_controller_model();
    idle_on = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on();
    test_self_tests();
    test_setup_gates_poll();
    test_forwarding();
    test_output_port_and_stops();

    test_queue_fill_drain(130);
    idle_on = 1'b0;
    test_command_sequences(80);
    idle_on = 1'b1;
    test_command_sequences(200);
    test_random_noise(120);
    test_queue_fill_drain(130);

    // back-to-back tail, no idling on either side
    idle_on = 1'b0;
    test_queue_fill_drain(50);
    test_command_sequences(50);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("ran %0d transactions, %0d results compared, %0d mismatching fields",
             items_sent, results_checked, err_count);
    $display("polls delivered %0d, pushes refused %0d, bytes forwarded %0d, stops %0d",
             polls_delivered, pushes_refused, bytes_forwarded, stops_seen);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
